FILE: rtl/core/tlca_pkg.sv
`timescale 1ns / 1ps
package tlca_pkg;
	localparam int NODES_DEF = 1024;
	localparam int LEVELS_DEF = 10;
	localparam int DEPTH_W = 11;
	localparam int DIST_W = 26;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_DIST = 2'd1;
	localparam logic [1:0] ACT_KTH = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WAIT,
		ST_LD_WR0,
		ST_LD_UP_RD,
		ST_LD_UP_WAIT,
		ST_LD_UP_WR,
		ST_Q_RD,
		ST_Q_WAIT,
		ST_Q_SWAP,
		ST_LIFT_RD,
		ST_LIFT_WAIT,
		ST_CMP_RDU,
		ST_CMP_WAITU,
		ST_CMP_RDV,
		ST_CMP_WAITV,
		ST_CMP_STEP,
		ST_TOP_RD,
		ST_TOP_WAIT,
		ST_T_RD,
		ST_T_WAIT,
		ST_ANS,
		ST_KLIFT_RD,
		ST_KLIFT_WAIT,
		ST_OUT
	} state_t;
endpackage

FILE: rtl/core/tlca_if.sv
`timescale 1ns / 1ps
interface tlca_req_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [9:0] node_a;
	logic [9:0] node_b;
	logic [15:0] edge_weight;
	logic [10:0] kth_position;
	modport source (output valid, action, node_a, node_b, edge_weight, kth_position,
		input ready);
	modport sink (input valid, action, node_a, node_b, edge_weight, kth_position,
		output ready);
endinterface

interface tlca_rsp_if;
	logic valid;
	logic ready;
	logic [25:0] answer;
	logic bad_request;
	modport source (output valid, answer, bad_request, input ready);
	modport sink (input valid, answer, bad_request, output ready);
endinterface

FILE: rtl/core/tlca_store.sv
`timescale 1ns / 1ps
module tlca_store
	import tlca_pkg::*;
#(
	parameter int NODES = NODES_DEF,
	parameter int LEVELS = LEVELS_DEF,
	localparam int NW = $clog2(NODES),
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
	input  logic clk,
	input  logic anc_we,
	input  logic [NW-1:0] anc_wnode,
	input  logic [LW-1:0] anc_wlvl,
	input  logic [NW-1:0] anc_wdata,
	input  logic [NW-1:0] anc_rnode,
	input  logic [LW-1:0] anc_rlvl,
	output logic [NW-1:0] anc_rdata,
	input  logic nd_we,
	input  logic [NW-1:0] nd_wnode,
	input  logic [DEPTH_W-1:0] nd_wdepth,
	input  logic [DIST_W-1:0] nd_wdist,
	input  logic [NW-1:0] nd_rnode,
	output logic [DEPTH_W-1:0] nd_rdepth,
	output logic [DIST_W-1:0] nd_rdist
);
	logic [NW-1:0] anc_mem [NODES*LEVELS];
	logic [DEPTH_W+DIST_W-1:0] nd_mem [NODES];
	logic [DEPTH_W+DIST_W-1:0] nd_q;

	function automatic logic [$clog2(NODES*LEVELS)-1:0] addr(
		input logic [NW-1:0] n, input logic [LW-1:0] l);
		addr = $clog2(NODES*LEVELS)'(n) * $clog2(NODES*LEVELS)'(LEVELS)
			+ $clog2(NODES*LEVELS)'(l);
	endfunction

	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[addr(anc_wnode, anc_wlvl)] <= anc_wdata;
		end
		anc_rdata <= anc_mem[addr(anc_rnode, anc_rlvl)];
	end

	always_ff @(posedge clk) begin
		if (nd_we) begin
			nd_mem[nd_wnode] <= {nd_wdepth, nd_wdist};
		end
		nd_q <= nd_mem[nd_rnode];
	end

	assign nd_rdepth = nd_q[DEPTH_W+DIST_W-1:DIST_W];
	assign nd_rdist = nd_q[DIST_W-1:0];
endmodule

FILE: rtl/core/tree_lca_path_query_engine.sv
`timescale 1ns / 1ps
// binary-lifting lca engine for a weighted rooted tree
// req channel: action, node_a, node_b, edge_weight, kth_position
//   load (action 0) writes a node given its parent; parents must be loaded first
//   distance (1) and kth node (2) queries return one item on rsp; code 3 is dropped
// rsp channel: answer, bad_request, held in an output register until taken
// one request at a time: ready is low while a request is worked on and while
// a response waits, so a stalled receiver holds off new requests
// a load reads the parent's node entry and writes the node's depth, distance and
//   level 0 ancestor; each upper level is one ancestor table read, a wait for the
//   registered read and a write
// a distance query reads both nodes, lifts the deeper one to equal depth level
//   by level, then compares from the top level down; a kth query then lifts once
//   more; the single ancestor table read port makes u and v reads take turns
// reset clears the sequencer and the response valid; the tables are not
// cleared and nodes must be loaded before they are queried
module tree_lca_path_query_engine
	import tlca_pkg::*;
#(
	parameter int NODES = NODES_DEF,
	parameter int LIFT_LEVELS = LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	tlca_req_if.sink req,
	tlca_rsp_if.source rsp
);
	localparam int NW = $clog2(NODES);
	localparam int LW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam logic [LW-1:0] LTOP = LW'(LIFT_LEVELS - 1);

	state_t state_q, state_n;
	logic [1:0] act_q;
	logic [NW-1:0] a_q, b_q, u_q, v_q, t_q;
	logic [15:0] w_q;
	logic [10:0] k_q;
	logic [LW-1:0] lvl_q;
	logic [DEPTH_W-1:0] da_q, db_q, dt_q;
	logic [DIST_W-1:0] xa_q, xb_q, xt_q;
	logic [DEPTH_W-1:0] diff_q;
	logic [NW-1:0] au_q;
	logic [10:0] kk_q;
	logic phase_q;
	logic rv_q;
	logic [25:0] ans_q;
	logic bad_q;

	logic anc_we;
	logic [NW-1:0] anc_wnode, anc_wdata, anc_rnode, anc_rdata;
	logic [LW-1:0] anc_wlvl, anc_rlvl;
	logic nd_we;
	logic [NW-1:0] nd_rnode;
	logic [DEPTH_W-1:0] nd_rdepth, nd_wdepth;
	logic [DIST_W-1:0] nd_rdist, nd_wdist;

	tlca_store #(.NODES(NODES), .LEVELS(LIFT_LEVELS)) u_store (
		.clk(clk), .anc_we(anc_we), .anc_wnode(anc_wnode), .anc_wlvl(anc_wlvl),
		.anc_wdata(anc_wdata), .anc_rnode(anc_rnode), .anc_rlvl(anc_rlvl),
		.anc_rdata(anc_rdata), .nd_we(nd_we), .nd_wnode(a_q), .nd_wdepth(nd_wdepth),
		.nd_wdist(nd_wdist), .nd_rnode(nd_rnode), .nd_rdepth(nd_rdepth),
		.nd_rdist(nd_rdist)
	);

	wire last_lvl = (lvl_q == LTOP);
	wire root_ld = (a_q == b_q);
	wire diff_bit = diff_q[lvl_q];
	wire kk_bit = kk_q[lvl_q];
	wire [DIST_W-1:0] dist_sum = xa_q + xb_q - {xt_q[DIST_W-2:0], 1'b0};
	wire [11:0] count_w = 12'(da_q) + 12'(db_q) - {dt_q, 1'b0} + 12'd1;
	wire [11:0] dau = 12'(da_q) - 12'(dt_q);

	assign req.ready = (state_q == ST_IDLE) && !rv_q;
	assign rsp.valid = rv_q;
	assign rsp.answer = ans_q;
	assign rsp.bad_request = bad_q;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid && req.ready) begin
					priority case (req.action)
						ACT_LOAD: state_n = ST_LD_RD;
						ACT_NONE: state_n = ST_IDLE;
						default: state_n = ST_Q_RD;
					endcase
				end
			end
			ST_LD_RD: state_n = ST_LD_WAIT;
			ST_LD_WAIT: state_n = ST_LD_WR0;
			ST_LD_WR0: state_n = (LIFT_LEVELS > 1) ? ST_LD_UP_RD : ST_IDLE;
			ST_LD_UP_RD: state_n = ST_LD_UP_WAIT;
			ST_LD_UP_WAIT: state_n = ST_LD_UP_WR;
			ST_LD_UP_WR: state_n = last_lvl ? ST_IDLE : ST_LD_UP_RD;
			ST_Q_RD: state_n = ST_Q_WAIT;
			ST_Q_WAIT: state_n = phase_q ? ST_Q_SWAP : ST_Q_RD;
			ST_Q_SWAP: state_n = ST_LIFT_RD;
			ST_LIFT_RD: state_n = ST_LIFT_WAIT;
			ST_LIFT_WAIT: state_n = last_lvl ? ST_CMP_RDU : ST_LIFT_RD;
			ST_CMP_RDU: state_n = ST_CMP_WAITU;
			ST_CMP_WAITU: state_n = ST_CMP_RDV;
			ST_CMP_RDV: state_n = ST_CMP_WAITV;
			ST_CMP_WAITV: state_n = ST_CMP_STEP;
			ST_CMP_STEP: state_n = (lvl_q == '0) ? ST_TOP_RD : ST_CMP_RDU;
			ST_TOP_RD: state_n = ST_TOP_WAIT;
			ST_TOP_WAIT: state_n = ST_T_RD;
			ST_T_RD: state_n = ST_T_WAIT;
			ST_T_WAIT: state_n = ST_ANS;
			ST_ANS: state_n = (act_q == ACT_DIST || k_q == '0 || 12'(k_q) > count_w)
				? ST_OUT : ST_KLIFT_RD;
			ST_KLIFT_RD: state_n = ST_KLIFT_WAIT;
			ST_KLIFT_WAIT: state_n = last_lvl ? ST_OUT : ST_KLIFT_RD;
			ST_OUT: state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// memory port drive
	always_comb begin
		anc_we = 1'b0;
		anc_wnode = a_q;
		anc_wlvl = lvl_q;
		anc_wdata = anc_rdata;
		anc_rnode = u_q;
		anc_rlvl = lvl_q;
		nd_we = 1'b0;
		nd_rnode = b_q;
		nd_wdepth = root_ld ? '0 : nd_rdepth + DEPTH_W'(1);
		nd_wdist = root_ld ? '0 : nd_rdist + DIST_W'(w_q);
		unique case (state_q)
			ST_LD_WR0: begin
				anc_we = 1'b1;
				anc_wlvl = '0;
				anc_wdata = b_q;
				nd_we = 1'b1;
			end
			// address held through the wait so the read data survives to the write
			ST_LD_UP_RD, ST_LD_UP_WAIT: begin
				anc_rnode = au_q;
				anc_rlvl = lvl_q - LW'(1);
			end
			ST_LD_UP_WR: anc_we = 1'b1;
			ST_Q_RD: nd_rnode = phase_q ? b_q : a_q;
			ST_CMP_RDV, ST_CMP_WAITV: anc_rnode = v_q;
			ST_TOP_RD: anc_rlvl = '0;
			ST_T_RD: nd_rnode = t_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (rsp.valid && rsp.ready) begin
				rv_q <= 1'b0;
			end
			if (state_q == ST_OUT) begin
				rv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				act_q <= req.action;
				a_q <= NW'(req.node_a % NODES);
				b_q <= NW'(req.node_b % NODES);
				w_q <= req.edge_weight;
				k_q <= req.kth_position;
				phase_q <= 1'b0;
				lvl_q <= '0;
			end
			ST_LD_WR0: begin
				au_q <= b_q;
				lvl_q <= LW'(1);
			end
			ST_LD_UP_WR: begin
				au_q <= anc_rdata;
				lvl_q <= lvl_q + LW'(1);
			end
			ST_Q_WAIT: begin
				if (!phase_q) begin
					da_q <= nd_rdepth;
					xa_q <= nd_rdist;
				end else begin
					db_q <= nd_rdepth;
					xb_q <= nd_rdist;
				end
				phase_q <= 1'b1;
			end
			ST_Q_SWAP: begin
				if (da_q < db_q) begin
					u_q <= b_q;
					v_q <= a_q;
					diff_q <= db_q - da_q;
				end else begin
					u_q <= a_q;
					v_q <= b_q;
					diff_q <= da_q - db_q;
				end
				dt_q <= (da_q < db_q) ? da_q : db_q;
				lvl_q <= '0;
			end
			ST_LIFT_WAIT: begin
				if (diff_bit) u_q <= anc_rdata;
				lvl_q <= last_lvl ? LTOP : lvl_q + LW'(1);
			end
			ST_CMP_WAITU: au_q <= anc_rdata;
			ST_CMP_STEP: begin
				if (au_q != anc_rdata) begin
					u_q <= au_q;
					v_q <= anc_rdata;
				end
				if (lvl_q != '0) lvl_q <= lvl_q - LW'(1);
			end
			ST_TOP_WAIT: t_q <= (u_q != v_q) ? anc_rdata : u_q;
			ST_T_WAIT: begin
				dt_q <= nd_rdepth;
				xt_q <= nd_rdist;
			end
			ST_ANS: begin
				bad_q <= (act_q == ACT_KTH) && (k_q == '0 || 12'(k_q) > count_w);
				ans_q <= (act_q == ACT_DIST) ? 26'(dist_sum) : '0;
				lvl_q <= '0;
				if (dau < 12'(k_q)) begin
					u_q <= b_q;
					kk_q <= 11'(count_w + 12'd1 - 12'(k_q) - 12'd1);
				end else begin
					u_q <= a_q;
					kk_q <= k_q - 11'd1;
				end
			end
			ST_KLIFT_WAIT: begin
				if (kk_bit) u_q <= anc_rdata;
				lvl_q <= lvl_q + LW'(1);
				if (last_lvl) ans_q <= 26'(kk_bit ? anc_rdata : u_q);
			end
			default: begin
			end
		endcase
	end
endmodule

FILE: rtl/core/tlca_checker.sv
`timescale 1ns / 1ps
module tlca_checker
	import tlca_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic [1:0] req_action,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [25:0] rsp_answer,
	input logic rsp_bad_request
);
	// no new request while a response waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("ready while response pending");
	// a response never follows a load directly
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_action == ACT_LOAD) |=> !rsp_valid)
		else $error("response after load");
	// bad request answers zero
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_bad_request) |-> rsp_answer == '0)
		else $error("bad request with nonzero answer");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_answer))
		else $error("response dropped");
endmodule

bind tree_lca_path_query_engine tlca_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.req_action(req.action), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_answer(rsp.answer), .rsp_bad_request(rsp.bad_request)
);
